// ----- hdl/aifp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the digit decoder for the ASCII integer field parser.
// No dependencies.
package aifp_pkg;

  // field widths
  localparam int CH_W    = 8;
  localparam int BASE_W  = 6;
  localparam int LEN_W   = 8;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 16;

  // stream packing widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 80;

  // character codes
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_X     = 8'h78;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;

  // radix limits
  localparam logic [BASE_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [BASE_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] RADIX_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] RADIX_AUTO = 6'd0;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] val;
  } digit_t;

  // value of a character as a digit in the given radix
  function automatic digit_t digit_of(input logic [CH_W-1:0] c, input logic [BASE_W-1:0] r);
    digit_t          d;
    logic [CH_W:0]   c_e;
    logic [CH_W:0]   r_e;
    logic [CH_W-1:0] diff;
    d.ok  = 1'b0;
    d.val = '0;
    c_e   = {1'b0, c};
    r_e   = {3'b000, r};
    if (r <= RADIX_DEC) begin
      diff = c - CH_ZERO;
      if (c >= CH_ZERO && c_e < ({1'b0, CH_ZERO} + r_e)) begin
        d.ok  = 1'b1;
        d.val = diff[BASE_W-1:0];
      end
    end else begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        diff  = c - CH_ZERO;
        d.ok  = 1'b1;
        d.val = diff[BASE_W-1:0];
      end
      if (c >= CH_UA && c_e < ({1'b0, CH_UA} + r_e - 9'd10)) begin
        diff  = c - CH_UA;
        d.ok  = 1'b1;
        d.val = diff[BASE_W-1:0] + 6'd10;
      end
      if (c >= CH_LA && c_e < ({1'b0, CH_LA} + r_e - 9'd10)) begin
        diff  = c - CH_LA;
        d.ok  = 1'b1;
        d.val = diff[BASE_W-1:0] + 6'd10;
      end
    end
    return d;
  endfunction

endpackage

// ----- hdl/ascii_integer_field_parser.sv -----
`timescale 1ns / 1ps
// Top level of the ASCII integer field parser: input register, field state and result register.
// Depends on aifp_pkg.

// The parser takes one character per cycle and gives one result when a field
// ends, via the input register and then the result register. A request with
// in_tuser set opens a new field and brings its radix and length limit; radix 0
// picks 16, 8 or 10 from the prefix. The value comes out already signed and
// wrapped modulo 2^64. The rate is one character per cycle, set by the
// accumulator loop: one multiply by the radix and one add per character. The
// input side takes one more character while a result waits, and stalls when
// that held character meets a result that has not been taken.
module ascii_integer_field_parser
  import aifp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // ch[7:0], base[13:8], max_len[21:14], zero fill
  input  logic                  in_tuser,   // start_req
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // value[63:0], chars_used[79:64]
  output logic                  out_tuser   // pushed_back
);

  // field phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  logic              in_valid_r;
  logic [CH_W-1:0]   in_ch_r;
  logic              in_start_r;
  logic [BASE_W-1:0] in_base_r;
  logic [LEN_W-1:0]  in_len_r;

  logic [2:0]        phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cons_r, cons_nxt;
  logic [BASE_W-1:0] radix_r, radix_nxt;
  logic [LEN_W-1:0]  limit_r, limit_nxt;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_pb_r;

  logic              advance;
  logic              fin;
  logic              pb;
  logic [CNT_W-1:0]  cnt_res;

  // handshake
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ch_r    <= in_tdata[7:0];
      in_base_r  <= in_tdata[13:8];
      in_len_r   <= in_tdata[21:14];
      in_start_r <= in_tuser;
    end
  end

  // field step for the held character
  always_comb begin
    logic              stop;
    logic              at_lim;
    digit_t            dg;
    logic [VAL_W-1:0]  dterm;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    cons_nxt  = cons_r;
    radix_nxt = radix_r;
    limit_nxt = limit_r;
    fin       = 1'b0;
    pb        = 1'b0;
    stop      = 1'b0;
    at_lim    = 1'b0;
    dg        = '0;
    dterm     = '0;
    cnt_res   = '0;

    // a start request reopens the field
    if (in_start_r) begin
      phase_nxt = PH_SIGN;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
      cons_nxt  = '0;
      radix_nxt = (in_base_r > RADIX_MAX) ? RADIX_MAX : in_base_r;
      limit_nxt = in_len_r;
    end

    if (in_start_r || phase_r != PH_IDLE) begin
      if (cons_nxt != CNT_MAX) begin
        cons_nxt = cons_nxt + 16'd1;
      end
      at_lim = (limit_nxt != '0) && (cons_nxt == {8'd0, limit_nxt});

      // optional sign
      if (phase_nxt == PH_SIGN) begin
        if (in_ch_r == CH_MINUS || in_ch_r == CH_PLUS) begin
          neg_nxt = (in_ch_r == CH_MINUS);
          stop    = 1'b1;
          if (at_lim) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_PREFIX;
          end
        end else begin
          phase_nxt = PH_PREFIX;
        end
      end

      // radix prefix
      if (!stop) begin
        if (phase_nxt == PH_PREFIX) begin
          if (radix_nxt == RADIX_AUTO) begin
            if (in_ch_r != CH_ZERO) begin
              radix_nxt = RADIX_DEC;
            end else begin
              stop = 1'b1;
              if (at_lim) begin
                fin = 1'b1;
              end else begin
                phase_nxt = PH_ZERO;
              end
            end
          end
          if (!stop) begin
            phase_nxt = PH_DIGITS;
          end
        end else if (phase_nxt == PH_ZERO) begin
          if (in_ch_r != CH_X) begin
            radix_nxt = RADIX_OCT;
            phase_nxt = PH_DIGITS;
          end else begin
            radix_nxt = RADIX_HEX;
            stop      = 1'b1;
            if (at_lim) begin
              fin = 1'b1;
            end else begin
              phase_nxt = PH_DIGITS;
            end
          end
        end
      end

      // digits, accumulated with the sign already applied
      if (!stop) begin
        dg = digit_of(in_ch_r, radix_nxt);
        if (in_ch_r == CH_NUL) begin
          fin = 1'b1;
        end else if (!dg.ok) begin
          fin = 1'b1;
          pb  = 1'b1;
        end else begin
          dterm   = neg_nxt ? (64'd0 - {58'd0, dg.val}) : {58'd0, dg.val};
          acc_nxt = acc_nxt * {58'd0, radix_nxt} + dterm;
          if (at_lim) begin
            fin = 1'b1;
          end
        end
      end
    end

    // count seen by the result, push-back not counted
    cnt_res = cons_nxt;
    if (pb && cons_nxt != '0 && cons_nxt != CNT_MAX) begin
      cnt_res = cons_nxt - 16'd1;
    end
    if (fin) begin
      phase_nxt = PH_IDLE;
      cons_nxt  = cnt_res;
    end
  end

  // field state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      cons_r  <= '0;
      radix_r <= '0;
      limit_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      cons_r  <= cons_nxt;
      radix_r <= radix_nxt;
      limit_r <= limit_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fin;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fin) begin
      out_value_r <= acc_nxt;
      out_cnt_r   <= cnt_res;
      out_pb_r    <= pb;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_value_r};
  assign out_tuser  = out_pb_r;

endmodule

// ----- hdl/aifp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the ASCII integer field parser, bound to the top level.
// Depends on aifp_pkg.
module aifp_checker
  import aifp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset empties the result side
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a field with no characters is a push-back with value zero
  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[79:64] == 16'd0 |-> out_tuser && out_tdata[63:0] == 64'd0)
    else $error("empty field without push-back or with a value");

endmodule

bind ascii_integer_field_parser aifp_checker u_aifp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- test/tb_ascii_integer_field_parser.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the ASCII integer field parser: directed and random character
// streams, checked against a cycle-free predictor of the field scanner. Depends on aifp_pkg.
module tb_ascii_integer_field_parser;
  import aifp_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 600000;

  typedef enum logic [2:0] {PH_IDLE, PH_SIGN, PH_PREFIX, PH_ZERO, PH_DIGITS} parse_phase_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             pb;
  } field_result_t;

  // predictor of the field scanner and store of the results it expects
  class integer_field_predictor;
    parse_phase_t      phase;
    bit                negative;
    bit [VAL_W-1:0]    acc;
    int unsigned       consumed;
    bit [BASE_W-1:0]   radix;
    bit [LEN_W-1:0]    limit;
    field_result_t     expected_fields[$];
    int                mismatches;

    function new();
      phase      = PH_IDLE;
      negative   = 1'b0;
      acc        = '0;
      consumed   = 0;
      radix      = '0;
      limit      = '0;
      mismatches = 0;
    endfunction

    function bit field_open();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return expected_fields.size();
    endfunction

    // digit weight of a character, -1 if it is no digit of this radix
    function int digit_value(bit [CH_W-1:0] c, bit [BASE_W-1:0] r);
      int ci;
      int ri;
      ci = int'(c);
      ri = int'(r);
      if (ri <= 10) begin
        if (ci >= int'(CH_ZERO) && ci < int'(CH_ZERO) + ri) return ci - int'(CH_ZERO);
        return -1;
      end
      if (ci >= int'(CH_ZERO) && ci <= int'(CH_NINE)) return ci - int'(CH_ZERO);
      if (ci >= int'(CH_UA) && ci < int'(CH_UA) + ri - 10) return ci - int'(CH_UA) + 10;
      if (ci >= int'(CH_LA) && ci < int'(CH_LA) + ri - 10) return ci - int'(CH_LA) + 10;
      return -1;
    endfunction

    function bit at_limit();
      return limit != 0 && consumed == int'(limit);
    endfunction

    // close the open field and queue its result
    function void close_field(bit pb);
      field_result_t r;
      if (pb && consumed != 0 && consumed != int'(CNT_MAX)) consumed--;
      r.value = negative ? (64'd0 - acc) : acc;
      r.count = CNT_W'(consumed);
      r.pb    = pb;
      expected_fields.push_back(r);
      phase = PH_IDLE;
    endfunction

    // advance the scanner by one accepted character request
    function void note_char(bit [CH_W-1:0] c, bit start, bit [BASE_W-1:0] b,
                            bit [LEN_W-1:0] ml);
      int d;
      if (start) begin
        phase    = PH_SIGN;
        negative = 1'b0;
        acc      = '0;
        consumed = 0;
        radix    = (b > RADIX_MAX) ? RADIX_MAX : b;
        limit    = ml;
      end else if (phase == PH_IDLE) begin
        return;
      end
      if (consumed < int'(CNT_MAX)) consumed++;

      // optional sign
      if (phase == PH_SIGN) begin
        if (c == CH_MINUS || c == CH_PLUS) begin
          negative = (c == CH_MINUS);
          if (at_limit()) close_field(1'b0);
          else phase = PH_PREFIX;
          return;
        end
        phase = PH_PREFIX;
      end

      // automatic radix from the prefix
      if (phase == PH_PREFIX) begin
        if (radix == RADIX_AUTO) begin
          if (c != CH_ZERO) begin
            radix = RADIX_DEC;
          end else begin
            if (at_limit()) close_field(1'b0);
            else phase = PH_ZERO;
            return;
          end
        end
        phase = PH_DIGITS;
      end else if (phase == PH_ZERO) begin
        if (c != CH_X) begin
          radix = RADIX_OCT;
        end else begin
          radix = RADIX_HEX;
          if (at_limit()) close_field(1'b0);
          else phase = PH_DIGITS;
          return;
        end
        phase = PH_DIGITS;
      end

      // digits
      if (c == CH_NUL) begin
        close_field(1'b0);
        return;
      end
      d = digit_value(c, radix);
      if (d < 0) begin
        close_field(1'b1);
        return;
      end
      acc = acc * VAL_W'(radix) + VAL_W'(d);
      if (at_limit()) close_field(1'b0);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [OUT_DATA_W-1:0] tdata, logic tuser);
      field_result_t e;
      logic [VAL_W-1:0] v;
      logic [CNT_W-1:0] n;
      v = tdata[VAL_W-1:0];
      n = tdata[VAL_W+CNT_W-1:VAL_W];
      if (expected_fields.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with none expected: value %0d chars %0d pushed_back %0b",
                   $signed(v), n, tuser);
        return;
      end
      e = expected_fields.pop_front();
      if (v !== e.value || n !== e.count || tuser !== e.pb) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: value %0d/%0d chars %0d/%0d pushed_back %0b/%0b (exp/act)",
                   $signed(e.value), $signed(v), e.count, n, e.pb, tuser);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // ch[7:0], base[13:8], max_len[21:14], zero fill
  logic                  in_tuser;   // start_req
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // value[63:0], chars_used[79:64]
  logic                  out_tuser;  // pushed_back

  integer_field_predictor scanner;
  bit no_idle;
  bit hold_pending;
  int live_items;
  int cycles;

  ascii_integer_field_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_ascii_integer_field_parser: errors");
      $finish;
    end
  end

  // offer one character request and wait until it is taken
  task automatic send_item(bit [CH_W-1:0] c, bit start, bit [BASE_W-1:0] b,
                           bit [LEN_W-1:0] ml);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 10));
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (start || scanner.field_open()) live_items++;
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= {2'b00, ml, b, c};
    do @(posedge clk); while (!in_tready);
    scanner.note_char(c, start, b, ml);
  endtask

  // one field from a string; base and limit bits on later requests are noise
  task automatic send_text(string s, bit [BASE_W-1:0] b, bit [LEN_W-1:0] ml);
    for (int i = 0; i < s.len(); i++) begin
      if (i == 0) send_item(s[i], 1'b1, b, ml);
      else send_item(s[i], 1'b0, BASE_W'($urandom), LEN_W'($urandom));
    end
  endtask

  function automatic bit [CH_W-1:0] random_digit(int r);
    int v;
    if (r <= 1) return CH_ZERO;
    v = int'($urandom_range(0, r - 1));
    if (v < 10) return CH_W'(int'(CH_ZERO) + v);
    if ($urandom_range(0, 1) == 0) return CH_W'(int'(CH_LA) + v - 10);
    return CH_W'(int'(CH_UA) + v - 10);
  endfunction

  // well-formed field with random content and an optional terminator
  task automatic random_field();
    bit [BASE_W-1:0] b;
    bit [LEN_W-1:0]  ml;
    bit [CH_W-1:0]   q[$];
    int              sel;
    int              eff;
    int              ndig;
    sel = int'($urandom_range(0, 9));
    case (sel)
      0, 1, 2: b = RADIX_AUTO;
      3:       b = RADIX_DEC;
      4:       b = RADIX_HEX;
      5:       b = RADIX_OCT;
      6:       b = 6'd2;
      7:       b = RADIX_MAX;
      8:       b = BASE_W'($urandom_range(0, 36));
      default: b = ($urandom_range(0, 1) == 0) ? BASE_W'($urandom_range(37, 63)) : 6'd1;
    endcase
    sel = int'($urandom_range(0, 9));
    if (sel < 5) ml = '0;
    else if (sel < 8) ml = LEN_W'($urandom_range(1, 8));
    else ml = LEN_W'($urandom);
    eff = (b > RADIX_MAX) ? int'(RADIX_MAX) : int'(b);

    // sign
    sel = int'($urandom_range(0, 3));
    if (sel == 0) q.push_back(CH_MINUS);
    else if (sel == 1) q.push_back(CH_PLUS);

    // prefix under automatic radix
    if (eff == 0) begin
      sel = int'($urandom_range(0, 3));
      if (sel == 0) begin
        q.push_back(CH_ZERO);
        q.push_back(CH_X);
        eff = 16;
      end else if (sel == 1) begin
        q.push_back(CH_ZERO);
        eff = 8;
      end else begin
        eff = 10;
      end
    end

    ndig = int'($urandom_range(0, 22));
    repeat (ndig) q.push_back(random_digit(eff));

    // terminator
    sel = int'($urandom_range(0, 5));
    case (sel)
      0:       q.push_back(CH_NUL);
      1:       q.push_back(8'h2C);
      2:       q.push_back(CH_W'($urandom));
      3:       q.push_back(8'h20);
      default: ;
    endcase
    if (q.size() == 0) q.push_back(CH_W'($urandom));

    for (int i = 0; i < q.size(); i++) begin
      if (i == 0) send_item(q[i], 1'b1, b, ml);
      else send_item(q[i], 1'b0, BASE_W'($urandom), LEN_W'($urandom));
    end
  endtask

  // result sink with random stalls and one long hold-off
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = no_idle ? 0 : int'($urandom_range(0, 10));
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      scanner.check_result(out_tdata, out_tuser);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    bit hold_done;
    scanner      = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    no_idle      = 1'b0;
    hold_pending = 1'b0;
    hold_done    = 1'b0;
    live_items   = 0;
    cycles       = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: signs, prefixes, terminators, limits, odd radices
    send_text("-42;", RADIX_DEC, 8'd255);
    send_text("0x1f", RADIX_AUTO, 8'd0);
    send_item(CH_NUL, 1'b0, 6'd63, 8'd0);
    send_text("017 ", RADIX_AUTO, 8'd0);
    send_text("+Zz", RADIX_MAX, 8'd3);
    send_text("q", RADIX_DEC, 8'd0);
    send_text("-", RADIX_AUTO, 8'd1);
    send_text("0", RADIX_AUTO, 8'd1);
    send_text("0x", RADIX_AUTO, 8'd2);
    send_text("01", 6'd1, 8'd0);
    send_text("Y!", 6'd63, 8'd0);
    // ignored while no field is open
    send_item(8'h37, 1'b0, RADIX_DEC, 8'd0);
    // restart abandons the open field
    send_text("12", RADIX_DEC, 8'd0);
    send_text("9", RADIX_DEC, 8'd1);

    // random part
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 49) == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (!hold_done && live_items >= RANDOM_ITEMS / 2) begin
        // sink holds off while short fields keep coming back to back
        hold_done    = 1'b1;
        no_idle      = 1'b1;
        hold_pending = 1'b1;
        repeat (40) send_text($sformatf("%0d;", $urandom_range(0, 999)), RADIX_DEC, 8'd0);
        no_idle = 1'b0;
      end
      if ($urandom_range(0, 9) == 0)
        send_item(CH_W'($urandom), 1'($urandom_range(0, 1)), BASE_W'($urandom),
                  LEN_W'($urandom));
      else
        random_field();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain
    while (scanner.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scanner.mismatches == 0 && scanner.pending() == 0) begin
      $display("tb_ascii_integer_field_parser: clean");
    end else begin
      $display("tb_ascii_integer_field_parser: errors");
    end
    $finish;
  end

endmodule

// ----- ascii_integer_field_parser.f -----
hdl/aifp_pkg.sv
hdl/ascii_integer_field_parser.sv
hdl/aifp_checker.sv
test/tb_ascii_integer_field_parser.sv
